/* design/queue_little_law_monitor_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the queue monitor
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef QUEUE_LITTLE_LAW_MONITOR_CORE_DEFINES_SVH
`define QUEUE_LITTLE_LAW_MONITOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Invariant that must hold at every clock edge
`define QLLM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next
`define QLLM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define QLLM_ASSERT_ALWAYS(label, cond, msg)
`define QLLM_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

/* design/qllm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qllm_pkg
// Widths, command codes and helpers shared by the queue monitor.
// ----------------------------------------------------------------------------
package qllm_pkg;

    localparam int TIME_BITS = 32;
    localparam int ACC_BITS  = 64;
    localparam int CNT_BITS  = 32;

    localparam int FIELD_T_W = 32;
    localparam int EXT_W     = (TIME_BITS > FIELD_T_W) ? TIME_BITS : FIELD_T_W;
    localparam int PROD_W    = TIME_BITS + CNT_BITS;
    localparam int SUM_W     = ((PROD_W > ACC_BITS) ? PROD_W : ACC_BITS) + 1;

    localparam logic [ACC_BITS-1:0]  ACC_MAX  = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;

    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = 64;
    localparam int M_FIELDS_W = 417;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARRIVAL   = 2'd0,
        CMD_DEPARTURE = 2'd1,
        CMD_FINISH    = 2'd2
    } command_t;

    // Bring a 32-bit timestamp field to the internal time width
    function automatic logic [TIME_BITS-1:0] to_time(input logic [FIELD_T_W-1:0] v);
        logic [EXT_W-1:0] x;
        x = EXT_W'(v);
        return x[TIME_BITS-1:0];
    endfunction

    // Bring an internal time to the 32-bit output field
    function automatic logic [FIELD_T_W-1:0] from_time(input logic [TIME_BITS-1:0] v);
        logic [EXT_W-1:0] x;
        x = EXT_W'(v);
        return x[FIELD_T_W-1:0];
    endfunction

    function automatic logic [CNT_BITS-1:0] inc_sat(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_BITS'(1);
    endfunction

endpackage

/* design/qllm_area_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qllm_area_mac
// Saturating time-weighted area update: area + (t - last) * count.
// ----------------------------------------------------------------------------
module qllm_area_mac
    import qllm_pkg::*;
(
    input  logic [ACC_BITS-1:0]  area,
    input  logic [TIME_BITS-1:0] last_time,
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [CNT_BITS-1:0]  count,
    output logic [ACC_BITS-1:0]  area_upd
);

    logic [TIME_BITS-1:0] delta;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     sum;

    always_comb begin
        // the caller guarantees now_time is not below last_time
        delta = now_time - last_time;
        prod  = PROD_W'(delta) * PROD_W'(count);
        sum   = SUM_W'(area) + SUM_W'(prod);
        if (sum > SUM_W'(ACC_MAX)) begin
            area_upd = ACC_MAX;
        end else begin
            area_upd = sum[ACC_BITS-1:0];
        end
    end

endmodule

/* design/queue_little_law_monitor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_little_law_monitor_core
// Single-server queue event monitor with time-weighted Little's-law areas.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out, passing through the input
// register and then the result register. A new event is taken in every cycle
// while the output is not stalled; the rate is set by the state update, whose
// longest path runs through the 32x32 multiply and 64-bit saturating add of
// the area units. Output stalls back-pressure the input without losing an
// event. All statistics reset to zero at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "queue_little_law_monitor_core_defines.svh"

module queue_little_law_monitor_core
    import qllm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] event_time, [63:32] service_sample
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] queue_length, [63:32] peak_length, [64] server_busy,
    // [96:65] next_departure, [160:97] busy_total, [224:161] area_in_system,
    // [288:225] area_arrived, [352:289] area_departed,
    // [384:353] arrivals_seen, [416:385] departures_seen, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] event_error
    output logic [M_TUSER_W-1:0] m_tuser
);

    // input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [CMD_W-1:0]     in_user_reg;

    // result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic [M_TUSER_W-1:0] m_user_next;

    // queue state
    logic [CNT_BITS-1:0]  length_now_reg, length_now_next;
    logic [CNT_BITS-1:0]  length_peak_reg, length_peak_next;
    logic [TIME_BITS-1:0] departure_at_reg, departure_at_next;
    logic                 busy_flag_reg, busy_flag_next;
    logic [ACC_BITS-1:0]  service_sum_reg, service_sum_next;
    logic [ACC_BITS-1:0]  system_area_reg, system_area_next;
    logic [ACC_BITS-1:0]  arrival_area_reg, arrival_area_next;
    logic [ACC_BITS-1:0]  departure_area_reg, departure_area_next;
    logic [TIME_BITS-1:0] system_last_reg, system_last_next;
    logic [TIME_BITS-1:0] arrival_last_reg, arrival_last_next;
    logic [TIME_BITS-1:0] departure_last_reg, departure_last_next;
    logic [CNT_BITS-1:0]  arrival_total_reg, arrival_total_next;
    logic [CNT_BITS-1:0]  departure_total_reg, departure_total_next;

    logic                 out_ready;
    logic                 advance;
    logic                 error_next;

    command_t             cmd;
    logic [TIME_BITS-1:0] t_now;
    logic [FIELD_T_W-1:0] sample;
    logic                 backwards;
    logic [ACC_BITS-1:0]  system_area_upd;
    logic [ACC_BITS-1:0]  arrival_area_upd;
    logic [ACC_BITS-1:0]  departure_area_upd;
    logic [EXT_W:0]       dep_sum;
    logic [TIME_BITS-1:0] dep_start;
    logic [ACC_BITS:0]    svc_sum;
    logic [ACC_BITS-1:0]  svc_start;
    logic [CNT_BITS-1:0]  length_inc;
    logic [CNT_BITS-1:0]  length_dec;

    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign cmd    = command_t'(in_user_reg);
    assign t_now  = to_time(in_data_reg[FIELD_T_W-1:0]);
    assign sample = in_data_reg[S_TDATA_W-1:FIELD_T_W];

    qllm_area_mac u_system_mac (
        .area      (system_area_reg),
        .last_time (system_last_reg),
        .now_time  (t_now),
        .count     (length_now_reg),
        .area_upd  (system_area_upd)
    );

    qllm_area_mac u_arrival_mac (
        .area      (arrival_area_reg),
        .last_time (arrival_last_reg),
        .now_time  (t_now),
        .count     (arrival_total_reg),
        .area_upd  (arrival_area_upd)
    );

    qllm_area_mac u_departure_mac (
        .area      (departure_area_reg),
        .last_time (departure_last_reg),
        .now_time  (t_now),
        .count     (departure_total_reg),
        .area_upd  (departure_area_upd)
    );

    // service start values: departure time and busy sum, both saturating
    always_comb begin
        dep_sum = (EXT_W + 1)'(t_now) + (EXT_W + 1)'(sample);
        if (dep_sum > (EXT_W + 1)'(TIME_MAX)) begin
            dep_start = TIME_MAX;
        end else begin
            dep_start = dep_sum[TIME_BITS-1:0];
        end
        svc_sum = (ACC_BITS + 1)'(service_sum_reg) + (ACC_BITS + 1)'(sample);
        if (svc_sum > (ACC_BITS + 1)'(ACC_MAX)) begin
            svc_start = ACC_MAX;
        end else begin
            svc_start = svc_sum[ACC_BITS-1:0];
        end
        length_inc = inc_sat(length_now_reg);
        length_dec = length_now_reg - CNT_BITS'(1);
    end

    always_comb begin
        length_now_next      = length_now_reg;
        length_peak_next     = length_peak_reg;
        departure_at_next    = departure_at_reg;
        busy_flag_next       = busy_flag_reg;
        service_sum_next     = service_sum_reg;
        system_area_next     = system_area_reg;
        arrival_area_next    = arrival_area_reg;
        departure_area_next  = departure_area_reg;
        system_last_next     = system_last_reg;
        arrival_last_next    = arrival_last_reg;
        departure_last_next  = departure_last_reg;
        arrival_total_next   = arrival_total_reg;
        departure_total_next = departure_total_reg;
        backwards            = 1'b0;
        error_next           = 1'b0;

        case (cmd)
            CMD_ARRIVAL: begin
                backwards  = t_now < system_last_reg;
                error_next = backwards;
                if (!backwards) begin
                    system_area_next  = system_area_upd;
                    system_last_next  = t_now;
                    arrival_area_next = arrival_area_upd;
                    arrival_last_next = t_now;
                    if (length_now_reg == '0) begin
                        departure_at_next = dep_start;
                        busy_flag_next    = 1'b1;
                        service_sum_next  = svc_start;
                    end
                    length_now_next = length_inc;
                    if (length_inc > length_peak_reg) begin
                        length_peak_next = length_inc;
                    end
                    arrival_total_next = inc_sat(arrival_total_reg);
                end
            end
            CMD_DEPARTURE: begin
                backwards  = t_now < system_last_reg;
                error_next = backwards || (length_now_reg == '0);
                if (!error_next) begin
                    system_area_next    = system_area_upd;
                    system_last_next    = t_now;
                    departure_area_next = departure_area_upd;
                    departure_last_next = t_now;
                    length_now_next     = length_dec;
                    if (length_dec != '0) begin
                        departure_at_next = dep_start;
                        busy_flag_next    = 1'b1;
                        service_sum_next  = svc_start;
                    end else begin
                        departure_at_next = '0;
                        busy_flag_next    = 1'b0;
                    end
                    departure_total_next = inc_sat(departure_total_reg);
                end
            end
            CMD_FINISH: begin
                backwards  = t_now < system_last_reg;
                error_next = backwards;
                if (!backwards) begin
                    system_area_next    = system_area_upd;
                    system_last_next    = t_now;
                    arrival_area_next   = arrival_area_upd;
                    arrival_last_next   = t_now;
                    departure_area_next = departure_area_upd;
                    departure_last_next = t_now;
                end
            end
            default: begin
                // unused code: report the state unchanged
            end
        endcase
    end

    // pack the state after the event
    always_comb begin
        m_data_next = M_TDATA_W'({
            departure_total_next,
            arrival_total_next,
            64'(departure_area_next),
            64'(arrival_area_next),
            64'(system_area_next),
            64'(service_sum_next),
            busy_flag_next ? from_time(departure_at_next) : 32'd0,
            busy_flag_next,
            length_peak_next,
            length_now_next
        });
        m_user_next = M_TUSER_W'(error_next);
    end

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    // statistics state: advance once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_now_reg      <= '0;
            length_peak_reg     <= '0;
            departure_at_reg    <= '0;
            busy_flag_reg       <= 1'b0;
            service_sum_reg     <= '0;
            system_area_reg     <= '0;
            arrival_area_reg    <= '0;
            departure_area_reg  <= '0;
            system_last_reg     <= '0;
            arrival_last_reg    <= '0;
            departure_last_reg  <= '0;
            arrival_total_reg   <= '0;
            departure_total_reg <= '0;
        end else if (advance) begin
            length_now_reg      <= length_now_next;
            length_peak_reg     <= length_peak_next;
            departure_at_reg    <= departure_at_next;
            busy_flag_reg       <= busy_flag_next;
            service_sum_reg     <= service_sum_next;
            system_area_reg     <= system_area_next;
            arrival_area_reg    <= arrival_area_next;
            departure_area_reg  <= departure_area_next;
            system_last_reg     <= system_last_next;
            arrival_last_reg    <= arrival_last_next;
            departure_last_reg  <= departure_last_next;
            arrival_total_reg   <= arrival_total_next;
            departure_total_reg <= departure_total_next;
        end
    end

    `QLLM_ASSERT_ALWAYS(a_peak_covers_length, length_peak_reg >= length_now_reg, "peak below length")
    `QLLM_ASSERT_ALWAYS(a_busy_matches_length, busy_flag_reg == (length_now_reg != '0), "busy flag out of step with length")
    `QLLM_ASSERT_ALWAYS(a_idle_no_departure, busy_flag_reg || (departure_at_reg == '0), "departure scheduled while idle")
    `QLLM_ASSERT_NEXT(a_stall_holds_state, m_valid_reg && !m_tready, $stable(length_now_reg) && $stable(system_last_reg), "state moved during output stall")
    `QLLM_ASSERT_NEXT(a_error_keeps_counts, advance && error_next, $stable(arrival_total_reg) && $stable(departure_total_reg) && $stable(system_area_reg), "rejected event changed state")

endmodule
